### sv/sps_pkg.sv
// Package for the skewed predecessor search core.
// Holds table sizing, command and status codes, and the sequencer state type.
package sps_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = CNT_W + 1;
  localparam int KEY_W       = 32;
  localparam int FRAC_W      = 8;
  localparam int IN_W        = 40;
  localparam int OUT_W       = 40;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_NONE  = 2'd0,
    STAT_EXACT = 2'd1,
    STAT_PRED  = 2'd2,
    STAT_RSVD  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_t;

endpackage

### sv/sps_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/skewed_predecessor_search_core.sv
// Skewed predecessor search core: top level with key table and search sequencer.
// Depends on sps_pkg and sps_ram.
//
// Keys are appended into a 1024-entry table (command 1); the user must append
// them in ascending order, as the block itself does not enforce it. Command 0
// empties the table, command 2 searches it. The search probes at
// low + floor((high - low) * split_fraction / 256) and returns the key on an
// exact hit, else the largest probed key below the query (status 2), else
// status 0 with found_key all ones. Clear and append give no result; appends
// to a full table are dropped. Each probe of a query passes S_PROBE, the shared
// span-times-fraction multiplier, then S_CMP, the registered table read and
// compare; about 11 probes at a balanced split, up to entry_count probes at
// split_fraction 0. No new word is taken while a query runs. A finished result
// sits in an output register, so the next word is taken while it waits.
module skewed_predecessor_search_core
  import sps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [FRAC_W-1:0] cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // [1:0] command, [33:2] key, rest zero
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata   // [1:0] status, [33:2] found_key, rest zero
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [FRAC_W-1:0]       alpha_r;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [IDX_W-1:0] low_r, low_nxt;
  logic signed [IDX_W-1:0] high_r, high_nxt;
  logic [ADDR_W-1:0]       probe_r, probe_nxt;
  logic                    have_pred_r, have_pred_nxt;
  logic signed [KEY_W-1:0] pred_r, pred_nxt;
  logic                    exact_r, exact_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [KEY_W-1:0]        out_key_r, out_key_nxt;

  cmd_t                    in_cmd;
  logic signed [KEY_W-1:0] in_key;
  logic                    in_fire;
  logic                    search_live;
  logic                    out_load;

  logic signed [IDX_W-1:0] span_w;
  logic [ADDR_W+FRAC_W-1:0] prod;
  logic [ADDR_W-1:0]       probe_calc;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [ADDR_W-1:0]       ram_raddr;
  logic signed [KEY_W-1:0] ram_rdata;

  assign in_cmd  = cmd_t'(in_tdata[1:0]);
  assign in_key  = in_tdata[KEY_W+1:2];
  assign in_fire = in_tvalid && in_tready;

  // Shared probe unit: span times fraction, scaled back down, offset by low.
  assign span_w      = high_r - low_r;
  assign prod        = (ADDR_W+FRAC_W)'(span_w[ADDR_W-1:0]) * (ADDR_W+FRAC_W)'(alpha_r);
  assign probe_calc  = low_r[ADDR_W-1:0] + prod[ADDR_W+FRAC_W-1:FRAC_W];
  assign search_live = (low_r <= high_r);
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_tready);

  sps_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_key),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_cmd == CMD_QUERY) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        state_nxt = search_live ? S_CMP : S_DONE;
      end
      S_CMP: begin
        state_nxt = (ram_rdata == key_r) ? S_DONE : S_PROBE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = count_r[ADDR_W-1:0];
    ram_raddr = probe_calc;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        ram_we    = in_tvalid && in_cmd == CMD_APPEND &&
                    count_r < CNT_W'(TABLE_DEPTH);
      end
      S_PROBE, S_CMP, S_DONE: begin
        in_tready = 1'b0;
      end
      default: in_tready = 1'b0;
    endcase
  end

  // Datapath.
  always_comb begin
    count_nxt      = count_r;
    key_nxt        = key_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    probe_nxt      = probe_r;
    have_pred_nxt  = have_pred_r;
    pred_nxt       = pred_r;
    exact_nxt      = exact_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;

    if (in_fire) begin
      case (in_cmd)
        CMD_CLEAR: count_nxt = '0;
        CMD_APPEND: begin
          if (count_r < CNT_W'(TABLE_DEPTH)) count_nxt = count_r + CNT_W'(1);
        end
        CMD_QUERY: begin
          key_nxt       = in_key;
          low_nxt       = '0;
          high_nxt      = $signed({1'b0, count_r}) - $signed(IDX_W'(1));
          have_pred_nxt = 1'b0;
          pred_nxt      = '1;
          exact_nxt     = 1'b0;
        end
        default: ;
      endcase
    end

    if (state_r == S_PROBE) begin
      probe_nxt = probe_calc;
    end

    if (state_r == S_CMP) begin
      if (ram_rdata == key_r) begin
        exact_nxt = 1'b1;
      end else if (ram_rdata < key_r) begin
        if (!have_pred_r || ram_rdata > pred_r) begin
          pred_nxt      = ram_rdata;
          have_pred_nxt = 1'b1;
        end
        low_nxt = $signed(IDX_W'(probe_r) + IDX_W'(1));
      end else begin
        high_nxt = $signed(IDX_W'(probe_r)) - $signed(IDX_W'(1));
      end
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
      if (exact_r) begin
        out_status_nxt = STAT_EXACT;
        out_key_nxt    = key_r;
      end else if (have_pred_r) begin
        out_status_nxt = STAT_PRED;
        out_key_nxt    = pred_r;
      end else begin
        out_status_nxt = STAT_NONE;
        out_key_nxt    = '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      alpha_r     <= FRAC_W'(128);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) alpha_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    low_r        <= low_nxt;
    high_r       <= high_nxt;
    probe_r      <= probe_nxt;
    have_pred_r  <= have_pred_nxt;
    pred_r       <= pred_nxt;
    exact_r      <= exact_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W-KEY_W-2)'(0), out_key_r, out_status_r};

endmodule

### sv/sps_checker.sv
// Port-level checker for the skewed predecessor search core, bound to the top.
// Depends on sps_pkg and skewed_predecessor_search_core.
module sps_checker
  import sps_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // A stalled result word must stay offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Once a query word is taken, input ready goes low for the search.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1:0] == CMD_QUERY |=> !in_tready)
    else $error("input ready during a search");

  // No predecessor always carries an all-ones key, and the reserved status never shows.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] != STAT_RSVD) &&
                   (out_tdata[1:0] != STAT_NONE || out_tdata[KEY_W+1:2] == '1))
    else $error("bad result status or key");

endmodule

bind skewed_predecessor_search_core sps_checker u_sps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
